/* sv/upi_pkg.sv */
// ----------------------------------------------------------------------------
// upi_pkg: shared types and constants of the unicycle pose integrator
// Register map, command bundle, CORDIC arctangent table and the fixed
// arithmetic widths of the motion update.
// ----------------------------------------------------------------------------
package upi_pkg;

  // Field widths (fixed by the interface)
  localparam int INTERVAL_W = 10;
  localparam int START_W    = 32;
  localparam int HDG_W      = 16;
  localparam int SPEED_W    = 16;
  localparam int OUT_POS_W  = 32;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERVAL      = 2'd0,
    REG_START_X       = 2'd1,
    REG_START_Y       = 2'd2,
    REG_START_HEADING = 2'd3
  } cfg_reg_t;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd50;

  typedef struct packed {
    logic        [INTERVAL_W-1:0] interval_ms;
    logic signed [START_W-1:0]    start_x;
    logic signed [START_W-1:0]    start_y;
    logic signed [HDG_W-1:0]      start_heading;
  } cfg_t;

  // CORDIC: 32-bit binary angle (2^31 = pi), Q30 vector
  localparam int ATAN_N = 24;
  localparam int IDX_W  = 5;
  localparam int CW     = 34;
  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };
  localparam logic signed [CW-1:0] CORDIC_K    = 34'sd652032874;
  localparam logic signed [CW-1:0] ANG_HALF_PI = 34'sd1073741824;
  localparam logic signed [CW-1:0] ANG_PI      = 34'sd2147483648;

  // Velocity times interval, and the products after the CORDIC
  localparam int VD_W   = SPEED_W + INTERVAL_W + 1;
  localparam int PW     = CW + VD_W;
  localparam int GAIN_W = 26;
  localparam int PH_W   = VD_W + GAIN_W;
  // round(2^48 / (4096000 * pi))
  localparam logic signed [GAIN_W-1:0] HDG_GAIN = 26'sd21874089;

  // Position step: round(p / (1000 * 2^22)), half away from zero.
  // Divide by 1000 = multiply by ceil(2^45 / 1000), exact for any 36-bit
  // dividend; done as two 18-bit halves, low half first, then high half.
  localparam int POS_SHIFT = 22;
  localparam logic signed [PW-1:0] POS_HALF = 61'sd2097152000;
  localparam int DIV_W     = 36;
  localparam int HALF_W    = DIV_W / 2;
  localparam int RCP_W     = 36;
  localparam int RCP_SHIFT = 45;
  localparam logic [RCP_W-1:0] RCP_1000 = 36'd35184372089;
  localparam int PP_W      = HALF_W + RCP_W;
  localparam int ACC_W     = DIV_W + RCP_W;
  localparam int QUO_W     = ACC_W - RCP_SHIFT;
  localparam int DIV_STEPS = 2;

  // Controller to datapath commands
  typedef struct packed {
    logic             start;
    logic             rotate;
    logic [IDX_W-1:0] idx;
    logic             product;
    logic             round;
    logic             div_step;
    logic             commit;
    logic             reload;
  } cmd_t;

endpackage

/* sv/unicycle_pose_integrator.sv */
// Advance: taken in idle, then S = min(CORDIC_STEPS, 24) micro-rotations on the shared
//   CORDIC (one step a cycle), product, round, reciprocal divide by 1000 (low half,
//   then high half) and commit. Restart: straight to commit, reloading the start pose.
// One item is in flight at a time: no new beat is taken until the last has committed.
// A new input beat is taken while a result waits; its commit then stalls until taken.
// Reset (rst, synchronous): pose zero, interval 50 ms, start pose zero, no result.
// ----------------------------------------------------------------------------
// unicycle_pose_integrator: planar dead-reckoning pose integrator
// Keeps x, y (Q16.16 m) and a binary-angle heading. Each advance beat moves
// the position along the old heading by v*dt*cos / v*dt*sin (CORDIC), then
// adds omega*dt to the heading with wrap. Restart reloads the start pose.
// ----------------------------------------------------------------------------
module unicycle_pose_integrator #(
  parameter int POS_WIDTH    = 32,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration writes
  input  logic                                  cfg_we,
  input  logic [upi_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [upi_pkg::CFG_DATA_W-1:0]        cfg_data,
  // input beats
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  operation,
  input  logic signed [upi_pkg::SPEED_W-1:0]    lin_speed,
  input  logic signed [upi_pkg::SPEED_W-1:0]    turn_rate,
  // result beats
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [upi_pkg::OUT_POS_W-1:0]  pos_x,
  output logic signed [upi_pkg::OUT_POS_W-1:0]  pos_y,
  output logic signed [upi_pkg::HDG_W-1:0]      heading
);
  import upi_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  // interval and start pose
  upi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: one item in flight, handshakes on both sides
  upi_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // pose registers double as the output register: they only change on a
  // commit, and a commit waits until the previous result beat is taken
  upi_datapath #(
    .POS_WIDTH   (POS_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .lin_speed (lin_speed),
    .turn_rate (turn_rate),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .heading   (heading)
  );

endmodule

/* sv/upi_cfg.sv */
// ----------------------------------------------------------------------------
// upi_cfg: configuration register file
// Interval and start pose, written one register per beat, no read-back.
// ----------------------------------------------------------------------------
module upi_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [upi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [upi_pkg::CFG_DATA_W-1:0]  cfg_data,
  output upi_pkg::cfg_t                   cfg
);
  import upi_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.interval_ms   <= INTERVAL_RESET;
      regs.start_x       <= '0;
      regs.start_y       <= '0;
      regs.start_heading <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INTERVAL:      regs.interval_ms   <= cfg_data[INTERVAL_W-1:0];
        REG_START_X:       regs.start_x       <= $signed(cfg_data[START_W-1:0]);
        REG_START_Y:       regs.start_y       <= $signed(cfg_data[START_W-1:0]);
        REG_START_HEADING: regs.start_heading <= $signed(cfg_data[HDG_W-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

/* sv/upi_datapath.sv */
// ----------------------------------------------------------------------------
// upi_datapath: pose registers and motion arithmetic
// Shared CORDIC micro-rotation, product stage, rounding stage, reciprocal
// divide by 1000 in 18-bit halves, and the saturating pose update.
// ----------------------------------------------------------------------------
module upi_datapath #(
  parameter int POS_WIDTH   = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  upi_pkg::cmd_t                         cmd,
  input  upi_pkg::cfg_t                         cfg,
  input  logic signed [upi_pkg::SPEED_W-1:0]    lin_speed,
  input  logic signed [upi_pkg::SPEED_W-1:0]    turn_rate,
  output logic signed [upi_pkg::OUT_POS_W-1:0]  pos_x,
  output logic signed [upi_pkg::OUT_POS_W-1:0]  pos_y,
  output logic signed [upi_pkg::HDG_W-1:0]      heading
);
  import upi_pkg::*;

  localparam int AW    = ANGLE_WIDTH;
  localparam int MW    = (POS_WIDTH > DIV_W + 1) ? POS_WIDTH : DIV_W + 1;
  localparam int SUM_W = ((MW > START_W) ? MW : START_W) + 1;
  localparam int XW    = (POS_WIDTH > OUT_POS_W) ? POS_WIDTH : OUT_POS_W;
  localparam int H_SHIFT = 49 - AW;

  localparam logic signed [SUM_W-1:0] POS_MAX =
    {{(SUM_W-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] POS_MIN = ~POS_MAX;
  localparam logic signed [PH_W-1:0]  H_HALF  = PH_W'(1) <<< (H_SHIFT - 1);

  // pose state
  logic signed [POS_WIDTH-1:0] cur_x, cur_y;
  logic signed [AW-1:0]        cur_heading;

  // work registers
  logic signed [VD_W-1:0] vd, wd;
  logic signed [CW-1:0]   rx, ry, rz;
  logic                   rneg;
  logic signed [PW-1:0]   px, py;
  logic signed [PH_W-1:0] ph;
  logic                   x_neg, y_neg, h_neg;
  logic [DIV_W-1:0]       num_x, num_y;
  logic [ACC_W-1:0]       acc_x, acc_y;
  logic [AW-1:0]          dh;

  // combinational
  logic signed [CW-1:0]    z_ext, z0, xs, ys, at, x_n, y_n, z_n, c_val, s_val;
  logic                    neg0;
  logic signed [PW-1:0]    mag_x, mag_y;
  logic signed [PH_W-1:0]  mag_h;
  logic [HALF_W-1:0]       half_x, half_y;
  logic [PP_W-1:0]         pp_x, pp_y;
  logic signed [SUM_W-1:0] x_sum, y_sum;
  logic signed [AW-1:0]    start_ang, h_new;
  logic signed [HDG_W-1:0] h16_out;
  logic signed [XW-1:0]    x_ext, y_ext;

  function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > POS_MAX) c = POS_MAX;
    else if (v < POS_MIN) c = POS_MIN;
    return c[POS_WIDTH-1:0];
  endfunction

  // CORDIC setup: fold headings beyond +-pi/2 back by pi
  always_comb begin
    z_ext = CW'(cur_heading) <<< (32 - AW);
    z0    = z_ext;
    neg0  = 1'b0;
    if (z_ext > ANG_HALF_PI) begin
      z0   = z_ext - ANG_PI;
      neg0 = 1'b1;
    end else if (z_ext < -ANG_HALF_PI) begin
      z0   = z_ext + ANG_PI;
      neg0 = 1'b1;
    end
  end

  // one micro-rotation
  always_comb begin
    xs = rx >>> cmd.idx;
    ys = ry >>> cmd.idx;
    at = $signed({{(CW-32){1'b0}}, ATAN_TAB[cmd.idx]});
    if (!rz[CW-1]) begin
      x_n = rx - ys;
      y_n = ry + xs;
      z_n = rz - at;
    end else begin
      x_n = rx + ys;
      y_n = ry - xs;
      z_n = rz + at;
    end
    c_val = rneg ? -rx : rx;
    s_val = rneg ? -ry : ry;
  end

  // |p| + half in one add/subtract
  always_comb begin
    mag_x = px[PW-1]   ? (POS_HALF - px) : (px + POS_HALF);
    mag_y = py[PW-1]   ? (POS_HALF - py) : (py + POS_HALF);
    mag_h = ph[PH_W-1] ? (H_HALF - ph)   : (ph + H_HALF);
  end

  // reciprocal multiply, low half on the first divide cycle, high half next
  always_comb begin
    half_x = (cmd.idx == '0) ? num_x[HALF_W-1:0] : num_x[DIV_W-1:HALF_W];
    half_y = (cmd.idx == '0) ? num_y[HALF_W-1:0] : num_y[DIV_W-1:HALF_W];
    pp_x   = half_x * RCP_1000;
    pp_y   = half_y * RCP_1000;
  end

  // pose update
  always_comb begin
    if (cmd.reload) begin
      x_sum = SUM_W'($signed(cfg.start_x));
      y_sum = SUM_W'($signed(cfg.start_y));
      h_new = start_ang;
    end else begin
      x_sum = x_neg ? SUM_W'(cur_x) - $signed(SUM_W'({1'b0, acc_x[ACC_W-1 -: QUO_W]}))
                    : SUM_W'(cur_x) + $signed(SUM_W'({1'b0, acc_x[ACC_W-1 -: QUO_W]}));
      y_sum = y_neg ? SUM_W'(cur_y) - $signed(SUM_W'({1'b0, acc_y[ACC_W-1 -: QUO_W]}))
                    : SUM_W'(cur_y) + $signed(SUM_W'({1'b0, acc_y[ACC_W-1 -: QUO_W]}));
      h_new = h_neg ? cur_heading - $signed(dh) : cur_heading + $signed(dh);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      vd   <= VD_W'(lin_speed) * VD_W'($signed({1'b0, cfg.interval_ms}));
      wd   <= VD_W'(turn_rate) * VD_W'($signed({1'b0, cfg.interval_ms}));
      rx   <= CORDIC_K;
      ry   <= '0;
      rz   <= z0;
      rneg <= neg0;
    end else if (cmd.rotate) begin
      rx <= x_n;
      ry <= y_n;
      rz <= z_n;
    end
    if (cmd.product) begin
      px <= PW'(c_val) * PW'(vd);
      py <= PW'(s_val) * PW'(vd);
      ph <= PH_W'(wd) * PH_W'(HDG_GAIN);
    end
    if (cmd.round) begin
      x_neg <= px[PW-1];
      y_neg <= py[PW-1];
      h_neg <= ph[PH_W-1];
      num_x <= mag_x[POS_SHIFT +: DIV_W];
      num_y <= mag_y[POS_SHIFT +: DIV_W];
      dh    <= mag_h[H_SHIFT +: AW];
    end
    if (cmd.div_step) begin
      if (cmd.idx == '0) begin
        acc_x <= ACC_W'(pp_x);
        acc_y <= ACC_W'(pp_y);
      end else begin
        acc_x <= acc_x + {pp_x, {HALF_W{1'b0}}};
        acc_y <= acc_y + {pp_y, {HALF_W{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      cur_heading <= '0;
    end else if (cmd.commit) begin
      cur_x       <= sat_pos(x_sum);
      cur_y       <= sat_pos(y_sum);
      cur_heading <= h_new;
    end
  end

  // heading width conversion, rounded half away from zero where narrowing
  if (AW > HDG_W) begin : g_wide_angle
    localparam int HS = AW - HDG_W;
    logic [AW-1:0] a_mag, a_rnd;
    always_comb begin
      a_mag   = cur_heading[AW-1] ? AW'(-cur_heading) : AW'(cur_heading);
      a_rnd   = (a_mag + (AW'(1) << (HS - 1))) >> HS;
      h16_out = cur_heading[AW-1] ? -$signed(a_rnd[HDG_W-1:0])
                                  : $signed(a_rnd[HDG_W-1:0]);
    end
    assign start_ang = {cfg.start_heading, {HS{1'b0}}};
  end else if (AW == HDG_W) begin : g_same_angle
    assign h16_out   = cur_heading;
    assign start_ang = cfg.start_heading;
  end else begin : g_narrow_angle
    localparam int HS = HDG_W - AW;
    logic [HDG_W-1:0] s_mag, s_rnd;
    always_comb begin
      s_mag     = cfg.start_heading[HDG_W-1] ? HDG_W'(-cfg.start_heading)
                                             : HDG_W'(cfg.start_heading);
      s_rnd     = (s_mag + (HDG_W'(1) << (HS - 1))) >> HS;
      start_ang = cfg.start_heading[HDG_W-1] ? -$signed(s_rnd[AW-1:0])
                                             : $signed(s_rnd[AW-1:0]);
    end
    assign h16_out = {cur_heading, {HS{1'b0}}};
  end

  assign x_ext   = XW'(cur_x);
  assign y_ext   = XW'(cur_y);
  assign pos_x   = x_ext[OUT_POS_W-1:0];
  assign pos_y   = y_ext[OUT_POS_W-1:0];
  assign heading = h16_out;

endmodule

/* sv/upi_ctrl.sv */
// ----------------------------------------------------------------------------
// upi_ctrl: sequencer of the pose integrator
// Walks an advance through rotate, product, round, divide and commit, and a
// restart straight to commit; owns the input and output handshakes.
// ----------------------------------------------------------------------------
module upi_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          operation,
  output logic          out_valid,
  input  logic          out_ready,
  output upi_pkg::cmd_t cmd
);
  import upi_pkg::*;

  localparam int STEPS = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;
  localparam logic [IDX_W-1:0] LAST_ROT = IDX_W'(STEPS - 1);
  localparam logic [IDX_W-1:0] LAST_DIV = IDX_W'(DIV_STEPS - 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_ROTATE  = 6'b000010,
    S_PRODUCT = 6'b000100,
    S_ROUND   = 6'b001000,
    S_DIVIDE  = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic             reload, reload_next;
  logic             out_valid_next;
  logic             out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      reload    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      reload    <= reload_next;
      out_valid <= out_valid_next;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    reload_next = reload;
    cmd         = '0;
    cmd.idx     = cnt;
    cmd.reload  = reload;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start   = 1'b1;
          cnt_next    = '0;
          reload_next = operation;
          state_next  = operation ? S_DONE : S_ROTATE;
        end
      end
      S_ROTATE: begin
        cmd.rotate = 1'b1;
        cnt_next   = cnt + 1'b1;
        if (cnt == LAST_ROT) state_next = S_PRODUCT;
      end
      S_PRODUCT: begin
        cmd.product = 1'b1;
        state_next  = S_ROUND;
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        cnt_next   = '0;
        state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == LAST_DIV) state_next = S_DONE;
      end
      S_DONE: begin
        // hold the finished pose until the output beat is free
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (cmd.commit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("pose committed over an untaken result");
  a_valid_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result shown without a commit");
  a_reload_path: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && operation) |=> (cmd.reload && state == S_DONE))
    else $error("restart did not go straight to commit");
  a_rot_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROTATE) |-> (cnt <= LAST_ROT))
    else $error("CORDIC step index past last step");
`endif

endmodule

/* bench/unicycle_pose_integrator_tb.sv */
// ----------------------------------------------------------------------------
// unicycle_pose_integrator_tb: self-checking bench for the pose integrator
// Drives advance and restart beats with random gaps against a bit-exact
// pose predictor (CORDIC heading, rounded steps, saturation, heading wrap),
// checks every result beat in order and steps through several register setups.
// ----------------------------------------------------------------------------
module unicycle_pose_integrator_tb;
  import upi_pkg::*;

  // Block parameters (defaults of the block)
  localparam int POS_W = 32;
  localparam int ANG_W = 16;
  localparam int STEPS = 16;

  // Bench knobs
  localparam int     HALF_PERIOD  = 4;
  localparam int     IDLE_PCT     = 35;
  localparam int     RAND_PHASES  = 8;
  localparam int     PHASE_TICKS  = 160;
  localparam int     HOLD_CYCLES  = 700;
  localparam int     DRAIN_CYCLES = 60;
  localparam int     MAX_PRINTS   = 50;
  localparam longint RUN_LIMIT    = 64'd4_800_000;

  // Fixed-point constants of the motion update
  localparam longint ROT_GAIN  = 64'sd652032874;   // CORDIC start vector, Q30
  localparam longint HDG_SCALE = 64'sd21874089;    // round(2^48 / (4096000*pi))
  localparam longint STEP_DEN  = 64'sd4194304000;  // 1000 * 2^22
  localparam longint ANG32_HALF_PI = 64'sd1 <<< 30;
  localparam longint ANG32_PI      = 64'sd1 <<< 31;
  localparam longint ATAN_STEP [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  typedef enum logic {
    OP_ADVANCE = 1'b0,
    OP_RESTART = 1'b1
  } tick_op_t;

  typedef struct packed {
    tick_op_t           op;
    logic signed [15:0] speed;
    logic signed [15:0] rate;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] hdg;
  } pose_t;

  // DUT hookup; every input starts at a known value
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  operation = 1'b0;
  logic signed [15:0]    lin_speed = '0;
  logic signed [15:0]    turn_rate = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [31:0]    pos_x;
  logic signed [31:0]    pos_y;
  logic signed [15:0]    heading;

  // Predictor state: pose and its own copy of the registers
  longint ms_x, ms_y, ms_hdg;
  longint cfg_interval, cfg_sx, cfg_sy, cfg_sh;

  tick_t tick_queue[$];       // ticks waiting to be offered
  pose_t predicted_poses[$];  // poses owed by the block, oldest first
  tick_t offered;
  pose_t want_pose;
  logic  no_idle = 1'b0;      // both sides run flat out while set
  int    fail_count = 0;
  int    results_seen = 0;
  int    hold_left = 0;

  unicycle_pose_integrator #(
    .POS_WIDTH   (POS_W),
    .ANGLE_WIDTH (ANG_W),
    .CORDIC_STEPS(STEPS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .operation(operation),
    .lin_speed(lin_speed),
    .turn_rate(turn_rate),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .heading  (heading)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Pose predictor
  // ---------------------------------------------------------------------------

  // Two's complement wrap of a into w bits
  function automatic longint wrap_to(longint a, int w);
    longint m;
    m = 64'sd1 <<< w;
    a = a & (m - 1);
    if (a >= m / 2) a = a - m;
    return a;
  endfunction

  // Divide, rounding half away from zero (den > 0)
  function automatic longint round_div(longint p, longint den);
    longint h;
    h = den / 2;
    return (p >= 0) ? (p + h) / den : (p - h) / den;
  endfunction

  function automatic longint sat_pos(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (POS_W - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // 16-bit register heading to the internal angle width and back
  function automatic longint h16_to_angle(longint h);
    if (ANG_W >= 16) return wrap_to(h * (64'sd1 <<< (ANG_W - 16)), ANG_W);
    return wrap_to(round_div(h, 64'sd1 <<< (16 - ANG_W)), ANG_W);
  endfunction

  function automatic longint angle_to_h16(longint a);
    if (ANG_W >= 16) return wrap_to(round_div(a, 64'sd1 <<< (ANG_W - 16)), 16);
    return wrap_to(a * (64'sd1 <<< (16 - ANG_W)), 16);
  endfunction

  // cos/sin (Q30) of a heading by CORDIC rotation on a 32-bit binary angle.
  // Beyond +-pi/2 the angle is turned by pi first and the vector negated.
  function automatic void heading_cos_sin(input longint ang, output longint c,
                                          output longint s);
    longint z, x, y, t;
    logic   flip;
    z = ang * (64'sd1 <<< (32 - ANG_W));
    x = ROT_GAIN;
    y = 0;
    flip = 1'b0;
    if (z > ANG32_HALF_PI) begin
      z = z - ANG32_PI;
      flip = 1'b1;
    end else if (z < -ANG32_HALF_PI) begin
      z = z + ANG32_PI;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        x = t;
        z = z - ATAN_STEP[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        x = t;
        z = z + ATAN_STEP[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Apply one accepted tick to the predicted pose and return the result beat
  function automatic pose_t step_pose(tick_t tk);
    longint c, s, v, w, d, dx, dy, dh, h;
    pose_t  p;
    if (tk.op == OP_RESTART) begin
      ms_x   = sat_pos(cfg_sx);
      ms_y   = sat_pos(cfg_sy);
      ms_hdg = h16_to_angle(cfg_sh);
    end else begin
      v = tk.speed;
      w = tk.rate;
      d = cfg_interval;
      // position moves along the old heading
      heading_cos_sin(ms_hdg, c, s);
      dx = round_div(c * v * d, STEP_DEN);
      dy = round_div(s * v * d, STEP_DEN);
      dh = round_div(w * d * HDG_SCALE, 64'sd1 <<< (49 - ANG_W));
      ms_x   = sat_pos(ms_x + dx);
      ms_y   = sat_pos(ms_y + dy);
      ms_hdg = wrap_to(ms_hdg + dh, ANG_W);
    end
    h = angle_to_h16(ms_hdg);
    p.x = ms_x[31:0];
    p.y = ms_y[31:0];
    p.hdg = h[15:0];
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    fail_count++;
    if (fail_count <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Driver: offers queued ticks with random gaps. The tick being accepted is
  // predicted at the accepting edge, before the next one is loaded.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predicted_poses.push_back(step_pose(offered));
      if (!in_valid || in_ready) begin
        if (tick_queue.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          offered = tick_queue.pop_front();
          in_valid  <= 1'b1;
          operation <= offered.op;
          lin_speed <= offered.speed;
          turn_rate <= offered.rate;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks result beats in order and drives out_ready. At two points
  // it holds off for HOLD_CYCLES so the block backs up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (predicted_poses.size() == 0) begin
          report_mismatch($sformatf("result with none pending: x=%0d y=%0d hdg=%0d",
                                    pos_x, pos_y, heading));
        end else begin
          want_pose = predicted_poses.pop_front();
          if (pos_x !== want_pose.x)
            report_mismatch($sformatf("pos_x %0d, want %0d", pos_x, want_pose.x));
          if (pos_y !== want_pose.y)
            report_mismatch($sformatf("pos_y %0d, want %0d", pos_y, want_pose.y));
          if (heading !== want_pose.hdg)
            report_mismatch($sformatf("heading %0d, want %0d", heading, want_pose.hdg));
        end
        if (results_seen == 300 || results_seen == 1100) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Register write; the predictor copy follows at once since the block is idle
  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_INTERVAL:      cfg_interval = longint'(value[9:0]);
      REG_START_X:       cfg_sx = wrap_to(longint'(value), 32);
      REG_START_Y:       cfg_sy = wrap_to(longint'(value), 32);
      REG_START_HEADING: cfg_sh = wrap_to(longint'(value[15:0]), 16);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_tick(tick_op_t op, logic [15:0] speed, logic [15:0] rate);
    tick_t t;
    t.op = op;
    t.speed = speed;
    t.rate = rate;
    tick_queue.push_back(t);
  endtask

  // Sender pause: nothing queued, nothing offered, no result owed
  task automatic drain();
    while (tick_queue.size() != 0 || in_valid || predicted_poses.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] random_field();
    case ($urandom_range(3))
      0:       return 16'(int'($urandom_range(4095)) - 2048);
      1:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_start_pos();
    case ($urandom_range(4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'(int'($urandom_range(1 << 24)) - (1 << 23));
      3:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] random_start_heading();
    case ($urandom_range(7))
      0:       return 16'h8000;   // -pi
      1:       return 16'h7FFF;
      2:       return 16'h4000;   // exactly pi/2, no half turn
      3:       return 16'h4001;
      4:       return 16'hC000;   // exactly -pi/2
      5:       return 16'hBFFF;
      6:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // New register setup per random phase; the first four hit interval extremes.
  // Unused upper data bits are sometimes set to show they are dropped.
  task automatic shuffle_setup(int ph);
    logic [31:0] iv;
    logic [31:0] hv;
    case ((ph < 4) ? ph : 4)
      0:       iv = 32'd1000;
      1:       iv = 32'd1;
      2:       iv = 32'd1023;
      3:       iv = 32'd0;
      default: iv = $urandom_range(1, 1000);
    endcase
    if ($urandom_range(1)) iv = iv | ($urandom & 32'hFFFF_FC00);
    hv = {16'h0, random_start_heading()};
    if ($urandom_range(1)) hv = hv | ($urandom & 32'hFFFF_0000);
    write_reg(REG_INTERVAL, iv);
    write_reg(REG_START_X, random_start_pos());
    write_reg(REG_START_Y, random_start_pos());
    write_reg(REG_START_HEADING, hv);
  endtask

  initial begin
    cfg_interval = 50;
    cfg_sx = 0;
    cfg_sy = 0;
    cfg_sh = 0;
    ms_x = 0;
    ms_y = 0;
    ms_hdg = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register defaults after reset: zero, extreme and unit velocities,
    // a restart whose velocity fields must be ignored
    @(negedge clk);
    queue_tick(OP_ADVANCE, 16'h0000, 16'h0000);
    queue_tick(OP_ADVANCE, 16'h7FFF, 16'h7FFF);
    queue_tick(OP_ADVANCE, 16'h8000, 16'h8000);
    queue_tick(OP_ADVANCE, 16'h0100, 16'h1000);
    queue_tick(OP_RESTART, 16'h1234, 16'hFFFF);
    queue_tick(OP_ADVANCE, 16'hFFFF, 16'hFFFF);
    queue_tick(OP_ADVANCE, 16'h7FFF, 16'h0000);
    drain();

    // Interval past 1000, start near the low x limit facing -pi:
    // x saturates low, then the heading wraps both ways
    write_reg(REG_INTERVAL, 32'd1023);
    write_reg(REG_START_X, 32'h8000_0100);
    write_reg(REG_START_Y, 32'h7FFF_FF00);
    write_reg(REG_START_HEADING, 32'h0000_8000);
    @(negedge clk);
    queue_tick(OP_RESTART, 16'h0000, 16'h0000);
    queue_tick(OP_ADVANCE, 16'h7FFF, 16'h0000);
    queue_tick(OP_ADVANCE, 16'h8000, 16'h0000);
    queue_tick(OP_ADVANCE, 16'h0000, 16'h7FFF);
    queue_tick(OP_ADVANCE, 16'h0000, 16'h8000);
    drain();

    // Zero interval: no motion at all
    write_reg(REG_INTERVAL, 32'd0);
    @(negedge clk);
    queue_tick(OP_ADVANCE, 16'h7FFF, 16'h7FFF);
    queue_tick(OP_RESTART, 16'h0000, 16'h0000);
    queue_tick(OP_ADVANCE, 16'h8000, 16'h8000);
    drain();

    // Start near the high corner at exactly pi/2: y saturates high
    write_reg(REG_INTERVAL, 32'd1000);
    write_reg(REG_START_X, 32'h7FFF_FF00);
    write_reg(REG_START_Y, 32'h7FFF_FF00);
    write_reg(REG_START_HEADING, 32'h0000_4000);
    @(negedge clk);
    queue_tick(OP_RESTART, 16'hFFFF, 16'h7FFF);
    queue_tick(OP_ADVANCE, 16'h7FFF, 16'h0000);
    queue_tick(OP_ADVANCE, 16'h7FFF, 16'h0000);
    queue_tick(OP_ADVANCE, 16'h0000, 16'h0001);
    queue_tick(OP_ADVANCE, 16'h0000, 16'hFFFF);
    drain();

    // Random phases: fresh registers each time, mostly advances with
    // occasional restarts. Phase 5 runs with no idling on either side.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      shuffle_setup(ph);
      @(negedge clk);
      no_idle <= (ph == 5);
      for (int n = 0; n < PHASE_TICKS; n++)
        queue_tick(($urandom_range(99) < 8) ? OP_RESTART : OP_ADVANCE,
                   random_field(), random_field());
      drain();
    end

    no_idle <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/upi_pkg.sv
sv/upi_cfg.sv
sv/upi_datapath.sv
sv/upi_ctrl.sv
sv/unicycle_pose_integrator.sv
bench/unicycle_pose_integrator_tb.sv
